// ===== rtl/i8fp_pkg.sv =====
// Shared types, constants and the data element table of the ISO 8583 field parser.
`default_nettype none

package i8fp_pkg;

  // Message size and element range
  localparam int MAX_MESSAGE_BYTES = 65536;
  localparam int FIELD_COUNT       = 128;
  localparam int OFFSET_W          = $clog2(MAX_MESSAGE_BYTES) + 1;

  // Bitmap and scan geometry
  localparam int BITMAP_BITS  = 64;
  localparam int BITMAP_BYTES = 8;
  localparam int MTI_BYTES    = 2;
  localparam int SCAN_BITS    = 2 * BITMAP_BITS;
  localparam int GROUP_W      = 8;
  localparam int GROUPS       = SCAN_BITS / GROUP_W;
  localparam int BITS_FIELD_BYTES = 8;

  localparam int LEN_W = 14;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_BAD_BCD  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ATTR_NONE  = 3'd0,
    ATTR_NUM   = 3'd1,
    ATTR_TRACK = 3'd2,
    ATTR_ALPHA = 3'd3,
    ATTR_BITS  = 3'd4
  } attr_t;

  typedef enum logic [1:0] {
    FMT_FIXED = 2'd0,
    FMT_LL    = 2'd1,
    FMT_LLL   = 2'd2
  } fmt_t;

  typedef struct packed {
    attr_t      attr;
    fmt_t       fmt;
    logic [7:0] max_len;
  } elem_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       field_number;
    logic [15:0]      field_start;
    logic [LEN_W-1:0] data_length;
    logic             message_done;
    status_t          status;
  } result_t;

  // Classified byte handed from the front to the walker
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       sop;
    logic       bcd_ok;
    logic [6:0] bcd_val;
  } tok_t;

  function automatic elem_t mk(input attr_t a, input fmt_t f, input logic [7:0] m);
    elem_t e;
    e.attr    = a;
    e.fmt     = f;
    e.max_len = m;
    return e;
  endfunction

  // Data element table; anything not listed has no entry
  function automatic elem_t elem_lookup(input logic [7:0] field);
    elem_t e;
    unique case (field)
      8'd2:                      e = mk(ATTR_NUM, FMT_LL, 8'd20);
      8'd3, 8'd11, 8'd12:        e = mk(ATTR_NUM, FMT_FIXED, 8'd6);
      8'd4, 8'd5, 8'd6:          e = mk(ATTR_NUM, FMT_FIXED, 8'd12);
      8'd7:                      e = mk(ATTR_NUM, FMT_FIXED, 8'd10);
      8'd8, 8'd9, 8'd10, 8'd28, 8'd29, 8'd30, 8'd31:
                                 e = mk(ATTR_NUM, FMT_FIXED, 8'd8);
      8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18:
                                 e = mk(ATTR_NUM, FMT_FIXED, 8'd4);
      8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24:
                                 e = mk(ATTR_NUM, FMT_FIXED, 8'd3);
      8'd25, 8'd26:              e = mk(ATTR_NUM, FMT_FIXED, 8'd2);
      8'd27:                     e = mk(ATTR_NUM, FMT_FIXED, 8'd1);
      8'd32, 8'd33:              e = mk(ATTR_NUM, FMT_LL, 8'd11);
      8'd34:                     e = mk(ATTR_NUM, FMT_LL, 8'd28);
      8'd35:                     e = mk(ATTR_TRACK, FMT_LL, 8'd37);
      8'd36:                     e = mk(ATTR_NUM, FMT_LLL, 8'd104);
      8'd37:                     e = mk(ATTR_ALPHA, FMT_FIXED, 8'd12);
      8'd38:                     e = mk(ATTR_ALPHA, FMT_FIXED, 8'd6);
      8'd39:                     e = mk(ATTR_ALPHA, FMT_FIXED, 8'd2);
      8'd40, 8'd49:              e = mk(ATTR_ALPHA, FMT_FIXED, 8'd3);
      8'd41:                     e = mk(ATTR_ALPHA, FMT_FIXED, 8'd8);
      8'd42:                     e = mk(ATTR_ALPHA, FMT_FIXED, 8'd15);
      8'd43:                     e = mk(ATTR_ALPHA, FMT_FIXED, 8'd40);
      8'd44:                     e = mk(ATTR_ALPHA, FMT_LL, 8'd0);
      8'd45:                     e = mk(ATTR_ALPHA, FMT_LL, 8'd76);
      8'd46, 8'd47, 8'd48, 8'd55:
                                 e = mk(ATTR_ALPHA, FMT_LLL, 8'd255);
      8'd52, 8'd64:              e = mk(ATTR_BITS, FMT_FIXED, 8'd64);
      8'd54, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63:
                                 e = mk(ATTR_ALPHA, FMT_LLL, 8'd0);
      default:                   e = mk(ATTR_NONE, FMT_FIXED, 8'd0);
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i8fp_front.sv =====
// Front end: takes message bytes, decodes the BCD nibbles and queues them for the walker.
`default_nettype none

module i8fp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire i8fp_pkg::in_item_t item,
  output logic                   full,
  output logic                   tok_valid,
  input  wire logic              tok_pop,
  output i8fp_pkg::tok_t         tok
);
  import i8fp_pkg::*;

  logic [3:0] hi;
  logic [3:0] lo;
  tok_t       tok_in;
  tok_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  // Classify: BCD digit check and value of the two nibbles
  always_comb begin
    hi = item.msg_byte[7:4];
    lo = item.msg_byte[3:0];
    tok_in.msg_byte = item.msg_byte;
    tok_in.sop      = item.start_of_message;
    tok_in.bcd_ok   = (hi <= 4'd9) && (lo <= 4'd9);
    tok_in.bcd_val  = 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
  end

  assign full      = (count == 2'd2);
  assign tok_valid = (count != 2'd0);
  assign tok       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = tok_pop && tok_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= tok_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i8fp_walker.sv =====
// Back end: header and bitmap capture, set-field walk, prefix and body counting.
`default_nettype none

module i8fp_walker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tok_valid,
  input  wire i8fp_pkg::tok_t tok,
  output logic                tok_pop,
  input  wire logic           out_space,
  output logic                res_push,
  output i8fp_pkg::result_t   res
);
  import i8fp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MTI, PH_BMP1, PH_BMP2, PH_NEXT, PH_PREFIX, PH_BODY, PH_HALT
  } phase_t;

  phase_t                phase, phase_next, ph_e;
  logic [BITMAP_BITS-1:0] bmp0, bmp0_next, bmp0_w;
  logic [BITMAP_BITS-1:0] bmp1, bmp1_next, bmp1_w;
  logic [SCAN_BITS-1:0]  pend, pend_next, cand, enc_in, nxt_oh;
  logic [7:0]            cf, cf_next, cf_e;
  logic [LEN_W-1:0]      rem, rem_next, rem_e, rdec_e;
  logic [LEN_W-1:0]      lacc, lacc_next;
  logic [OFFSET_W-1:0]   off, off_next, off_e;
  logic [15:0]           fso, fso_next;
  logic                  fire;
  elem_t                 d;

  logic [LEN_W-1:0]      p_lin, p_rin, p_rdec, p_lacc, p_body;
  logic [LEN_W:0]        p_sum;
  logic [15:0]           p_fs;
  logic [LEN_W-1:0]      f_lacc, f_rem, b_rin, b_rdec, b_lacc;
  logic [15:0]           b_fs;

  logic [GROUPS-1:0]     gany;
  logic [2:0]            gidx [GROUPS];
  logic [3:0]            sel_g;
  logic [6:0]            nxt_idx;
  logic                  found;
  logic [7:0]            nxt_field;

  logic                  prefix_go, body_go, cmp_go, walk_go;
  logic [LEN_W-1:0]      cmp_len;
  logic [15:0]           cmp_fs;

  function automatic logic [2:0] pri8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  assign fire    = tok_valid && out_space;
  assign tok_pop = fire;

  // Effective view of the state: a start byte restarts from the MTI
  always_comb begin
    ph_e   = tok.sop ? PH_MTI : phase;
    rem_e  = tok.sop ? LEN_W'(MTI_BYTES) : rem;
    off_e  = tok.sop ? '0 : off;
    cf_e   = tok.sop ? 8'd0 : cf;
    rdec_e = (rem_e != '0) ? rem_e - 1'b1 : '0;
    bmp0_w = (ph_e == PH_BMP1) ? {bmp0[BITMAP_BITS-9:0], tok.msg_byte} : bmp0;
    bmp1_w = (ph_e == PH_BMP2) ? {bmp1[BITMAP_BITS-9:0], tok.msg_byte} : bmp1;
    d      = elem_lookup(cf);
  end

  // Candidate set from the bitmaps; bit j stands for element j+1, bit 0 (element 1) is never a field
  always_comb begin
    cand = '0;
    for (int j = 1; j < BITMAP_BITS; j++) begin
      cand[j] = bmp0_w[BITMAP_BITS-1-j];
    end
    for (int j = BITMAP_BITS; j < FIELD_COUNT; j++) begin
      cand[j] = bmp1_w[SCAN_BITS-1-j];
    end
    enc_in = (ph_e == PH_BMP1 || ph_e == PH_BMP2) ? cand : pend;
  end

  // Lowest set element: eight-bit groups, then a pick among the groups
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gany[g] = |enc_in[g*GROUP_W +: GROUP_W];
      gidx[g] = pri8(enc_in[g*GROUP_W +: GROUP_W]);
    end
    sel_g     = (|gany[GROUPS/2-1:0]) ? {1'b0, pri8(gany[GROUPS/2-1:0])}
                                      : {1'b1, pri8(gany[GROUPS-1:GROUPS/2])};
    nxt_idx   = {sel_g, gidx[sel_g]};
    found     = |gany;
    nxt_field = 8'(nxt_idx) + 8'd1;
    nxt_oh    = SCAN_BITS'(1) << nxt_idx;
  end

  // Length prefix and body arithmetic
  always_comb begin
    p_lin  = (ph_e == PH_NEXT) ? '0 : lacc;
    p_rin  = (ph_e == PH_NEXT) ? ((d.fmt == FMT_LL) ? LEN_W'(1) : LEN_W'(2)) : rem;
    p_fs   = (ph_e == PH_NEXT) ? 16'(off_e) : fso;
    p_rdec = (p_rin != '0) ? p_rin - 1'b1 : '0;
    p_lacc = LEN_W'(p_lin * LEN_W'(100)) + LEN_W'(tok.bcd_val);
    p_sum  = (LEN_W+1)'(p_lacc) + 1'b1;
    p_body = (d.attr == ATTR_ALPHA) ? p_lacc : p_sum[LEN_W:1];

    if (d.attr == ATTR_BITS) begin
      f_lacc = LEN_W'(BITS_FIELD_BYTES);
      f_rem  = LEN_W'(BITS_FIELD_BYTES);
    end else begin
      f_lacc = LEN_W'(d.max_len);
      f_rem  = (d.attr == ATTR_ALPHA) ? LEN_W'(d.max_len)
                                      : LEN_W'((9'(d.max_len) + 9'd1) >> 1);
    end
    b_rin  = (ph_e == PH_NEXT) ? f_rem : rem;
    b_lacc = (ph_e == PH_NEXT) ? f_lacc : lacc;
    b_fs   = (ph_e == PH_NEXT) ? 16'(off_e) : fso;
    b_rdec = (b_rin != '0) ? b_rin - 1'b1 : '0;
  end

  always_comb begin
    phase_next = phase;
    bmp0_next  = bmp0;
    bmp1_next  = bmp1;
    pend_next  = pend;
    cf_next    = cf;
    rem_next   = rem;
    lacc_next  = lacc;
    off_next   = off;
    fso_next   = fso;
    res_push   = 1'b0;
    res        = '0;
    prefix_go  = 1'b0;
    body_go    = 1'b0;
    cmp_go     = 1'b0;
    walk_go    = 1'b0;
    cmp_len    = '0;
    cmp_fs     = '0;

    if (fire) begin
      if (tok.sop) begin
        bmp0_next = '0;
        bmp1_next = '0;
        pend_next = '0;
        cf_next   = '0;
        lacc_next = '0;
        fso_next  = '0;
        off_next  = '0;
        rem_next  = LEN_W'(MTI_BYTES);
      end
      if (!tok.sop && (phase == PH_IDLE || phase == PH_HALT)) begin
        // drop the byte
      end else if (off_e == OFFSET_W'(MAX_MESSAGE_BYTES)) begin
        phase_next       = PH_HALT;
        res_push         = 1'b1;
        res.field_number = cf_e;
        res.status       = ST_OVERFLOW;
      end else begin
        off_next = off_e + 1'b1;
        unique case (ph_e)
          PH_MTI: begin
            if (rdec_e == '0) begin
              phase_next = PH_BMP1;
              rem_next   = LEN_W'(BITMAP_BYTES);
            end else begin
              phase_next = PH_MTI;
              rem_next   = rdec_e;
            end
          end
          PH_BMP1: begin
            bmp0_next = bmp0_w;
            if (rdec_e != '0) begin
              rem_next = rdec_e;
            end else if (bmp0_w[BITMAP_BITS-1]) begin
              phase_next = PH_BMP2;
              rem_next   = LEN_W'(BITMAP_BYTES);
            end else begin
              walk_go = 1'b1;
            end
          end
          PH_BMP2: begin
            bmp1_next = bmp1_w;
            if (rdec_e != '0) begin
              rem_next = rdec_e;
            end else begin
              walk_go = 1'b1;
            end
          end
          PH_NEXT: begin
            if (d.attr == ATTR_NONE) begin
              phase_next       = PH_HALT;
              res_push         = 1'b1;
              res.field_number = cf;
              res.field_start  = 16'(off_e);
              res.status       = ST_UNKNOWN;
            end else begin
              fso_next = 16'(off_e);
              if (d.fmt != FMT_FIXED) begin
                prefix_go = 1'b1;
              end else begin
                body_go = 1'b1;
              end
            end
          end
          PH_PREFIX: prefix_go = 1'b1;
          PH_BODY:   body_go = 1'b1;
          PH_IDLE, PH_HALT: begin
          end
        endcase

        if (prefix_go) begin
          if (!tok.bcd_ok) begin
            phase_next       = PH_HALT;
            res_push         = 1'b1;
            res.field_number = cf;
            res.field_start  = p_fs;
            res.status       = ST_BAD_BCD;
          end else begin
            lacc_next = p_lacc;
            if (p_rdec != '0) begin
              rem_next   = p_rdec;
              phase_next = PH_PREFIX;
            end else if (p_body == '0) begin
              cmp_go  = 1'b1;
              cmp_len = p_lacc;
              cmp_fs  = p_fs;
            end else begin
              rem_next   = p_body;
              phase_next = PH_BODY;
            end
          end
        end

        if (body_go) begin
          lacc_next = b_lacc;
          if (b_rdec != '0) begin
            rem_next   = b_rdec;
            phase_next = PH_BODY;
          end else begin
            cmp_go  = 1'b1;
            cmp_len = b_lacc;
            cmp_fs  = b_fs;
          end
        end

        if (cmp_go) begin
          res_push         = 1'b1;
          res.field_number = cf;
          res.field_start  = cmp_fs;
          res.data_length  = cmp_len;
          res.message_done = !found;
          res.status       = ST_OK;
        end else if (walk_go && !found) begin
          res_push         = 1'b1;
          res.message_done = 1'b1;
          res.status       = ST_OK;
        end

        // Advance to the next set element, or stop at the end of the message
        if (cmp_go || walk_go) begin
          if (found) begin
            cf_next    = nxt_field;
            pend_next  = enc_in & ~nxt_oh;
            phase_next = PH_NEXT;
          end else begin
            phase_next = PH_HALT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bmp0  <= '0;
      bmp1  <= '0;
      pend  <= '0;
      cf    <= '0;
      rem   <= '0;
      lacc  <= '0;
      off   <= '0;
      fso   <= '0;
    end else begin
      phase <= phase_next;
      bmp0  <= bmp0_next;
      bmp1  <= bmp1_next;
      pend  <= pend_next;
      cf    <= cf_next;
      rem   <= rem_next;
      lacc  <= lacc_next;
      off   <= off_next;
      fso   <= fso_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i8fp_outq.sv =====
// Two-entry result queue that parts the walker from the result consumer.
`default_nettype none

module i8fp_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire i8fp_pkg::result_t din,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output i8fp_pkg::result_t      dout
);
  import i8fp_pkg::*;

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iso8583_field_parser.sv =====
// Top level of the ISO 8583 field parser: front queue, walker and result queue.
`default_nettype none

// ISO 8583 field parser. Push the packed message one byte per beat, with
// start_of_message high on the first MTI byte; that beat restarts the parser
// wherever it stands. After the two MTI bytes and the primary bitmap (and the
// secondary bitmap when bitmap bit 1 is set) the set data elements are walked
// in ascending order and one result beat is given on the last byte of each:
// element number, offset of its length prefix or body, decoded length and a
// done flag on the last one. A message with no elements set gives a single
// done beat with element 0. An element with no table entry, a length prefix
// nibble above 9 or a message longer than MAX_MESSAGE_BYTES gives one error
// beat and the parser then drops bytes until the next start. The block takes
// one byte per clock cycle while the result queue has room, including across
// field and message boundaries; the walker, fed through a two-entry byte
// queue, handles one byte per cycle under the same condition and finds the
// next set element with a combinational priority encoder over the 128 bitmap
// bits. The completing byte passes the byte queue, and its result is then
// registered in a two-entry result queue, so a stalled consumer holds the
// input only once both queues are full. No clearing pass follows reset.
module iso8583_field_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire i8fp_pkg::in_item_t item,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output i8fp_pkg::result_t       result
);
  import i8fp_pkg::*;

  logic    tok_valid;
  logic    tok_pop;
  tok_t    tok;
  logic    oq_full;
  logic    res_push;
  result_t res;

  // Front: take bytes, decode the BCD nibbles, queue them
  i8fp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop),
    .tok       (tok)
  );

  // Back: walk the header, bitmaps and elements; advance only with room for a result
  i8fp_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .out_space (!oq_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Hold results until the consumer takes each beat
  i8fp_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (oq_full),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

  // No result may be pushed into a full result queue
  a_no_result_loss: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !oq_full)
    else $error("result pushed into full queue");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

  // A done beat always carries a good status
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.message_done) |-> (result.status == ST_OK))
    else $error("done beat with error status");

  // A good beat with no element can only be the empty-message done beat
  a_empty_msg: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_OK && result.field_number == 8'd0)
      |-> (result.message_done && result.data_length == '0))
    else $error("element-less good beat without done");

endmodule

`default_nettype wire
